// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; the using scope supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked only out of reset.
`define ESL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked during reset as well.
`define ESL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/core/esl_pkg.sv
// Shared constants of the edge slope limiter.
// No dependencies.
package esl_pkg;
	// limiter strength register: unsigned Q2.16, reset 1.0
	localparam int unsigned BETA_WIDTH = 18;
	localparam logic [BETA_WIDTH-1:0] BETA_RESET = 18'd65536;
endpackage

// File: rtl/core/esl_front.sv
// Front stages: bounds, edge deltas and beta*numerator products.
// Depends on esl_pkg.
module esl_front #(
	parameter int VW = 32,
	parameter int SW = 199
) (
	input  logic clk,
	input  logic [1:0] en,
	input  logic [esl_pkg::BETA_WIDTH-1:0] beta,
	input  logic signed [VW-1:0] centre,
	input  logic signed [VW-1:0] nbr [3],
	input  logic [2:0] mask,
	input  logic signed [VW-1:0] edge_v [3],
	input  logic signed [VW-1:0] gx,
	input  logic signed [VW-1:0] gy,
	input  logic last,
	output logic [VW+esl_pkg::BETA_WIDTH-1:0] num [3],
	output logic [VW-1:0] den [3],
	output logic [SW-1:0] side
);
	import esl_pkg::*;
	localparam int NW = VW + BETA_WIDTH;

	logic signed [VW-1:0] qc_s1, gx_s1, gy_s1;
	logic signed [VW:0] dq_s1 [3];
	logic [VW-1:0] nmax_s1, nmin_s1;
	logic last_s1;
	logic signed [VW:0] dq_s2 [3];
	logic signed [VW-1:0] qc_s2, gx_s2, gy_s2;
	logic last_s2;
	logic [2:0] dz_s2;
	logic [NW-1:0] num_s2 [3];
	logic [VW-1:0] den_s2 [3];
	logic signed [VW-1:0] qmin, qmax;
	logic signed [VW:0] dmax, dmin;

	// bounds over centre and present neighbours
	always_comb begin
		qmin = centre;
		qmax = centre;
		for (int i = 0; i < 3; i++) begin
			if (mask[i]) begin
				if (nbr[i] < qmin) qmin = nbr[i];
				if (nbr[i] > qmax) qmax = nbr[i];
			end
		end
		dmax = {qmax[VW-1], qmax} - {centre[VW-1], centre};
		dmin = {centre[VW-1], centre} - {qmin[VW-1], qmin};
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (en[0]) begin
			qc_s1 <= centre;
			gx_s1 <= gx;
			gy_s1 <= gy;
			last_s1 <= last;
			nmax_s1 <= dmax[VW-1:0];
			nmin_s1 <= dmin[VW-1:0];
			for (int i = 0; i < 3; i++)
				dq_s1[i] <= {edge_v[i][VW-1], edge_v[i]} - {centre[VW-1], centre};
		end
	end

	// stage 2: magnitudes and beta times the bound distance
	always_ff @(posedge clk) begin
		if (en[1]) begin
			qc_s2 <= qc_s1;
			gx_s2 <= gx_s1;
			gy_s2 <= gy_s1;
			last_s2 <= last_s1;
			for (int i = 0; i < 3; i++) begin
				dq_s2[i] <= dq_s1[i];
				dz_s2[i] <= (dq_s1[i] == '0);
				den_s2[i] <= dq_s1[i][VW] ? VW'(-dq_s1[i]) : dq_s1[i][VW-1:0];
				num_s2[i] <= NW'(beta) * NW'(dq_s1[i][VW] ? nmin_s1 : nmax_s1);
			end
		end
	end

	assign num = num_s2;
	assign den = den_s2;
	assign side = SW'({dz_s2, last_s2, gy_s2, gx_s2, qc_s2, dq_s2[2], dq_s2[1], dq_s2[0]});
endmodule

// File: rtl/core/esl_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on esl_pkg.
module esl_div #(
	parameter int NW = 50,
	parameter int DW = 32,
	parameter int QB = 18
) (
	input  logic clk,
	input  logic [QB:0] en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QB-1:0] quo,
	output logic ovf
);
	import esl_pkg::*;
	localparam int CW = (NW - QB > DW) ? NW - QB : DW;

	logic [DW-1:0] rem_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] low_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic ovf_s [QB+1];
	logic [CW-1:0] hi_ext, den_ext;

	assign hi_ext = CW'(num[NW-1:QB]);
	assign den_ext = CW'(den);

	// entry: quotient too large for QB bits means overflow
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ovf_s[0] <= (hi_ext >= den_ext);
			rem_s[0] <= hi_ext[DW-1:0];
			den_s[0] <= den;
			low_s[0] <= num[QB-1:0];
			quo_s[0] <= '0;
		end
	end

	// one shift-and-subtract step per stage
	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DW:0] trial;
		logic take;
		assign trial = {rem_s[k-1], low_s[k-1][QB-k]};
		assign take = (trial >= {1'b0, den_s[k-1]});
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= take ? DW'(trial - {1'b0, den_s[k-1]}) : trial[DW-1:0];
				quo_s[k] <= {quo_s[k-1][QB-2:0], take};
				den_s[k] <= den_s[k-1];
				low_s[k] <= low_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];
endmodule

// File: rtl/core/esl_back.sv
// Back stages: phi selection, products, rescale with saturation, vertices.
// Depends on esl_pkg.
module esl_back #(
	parameter int VW = 32,
	parameter int F = 16,
	parameter int SW = 199
) (
	input  logic clk,
	input  logic [3:0] en,
	input  logic [esl_pkg::BETA_WIDTH-1:0] beta,
	input  logic [F+1:0] quo [3],
	input  logic [2:0] ovf,
	input  logic [SW-1:0] side,
	output logic signed [VW-1:0] edge_lim [3],
	output logic signed [VW-1:0] vertex [3],
	output logic signed [VW-1:0] gx_out,
	output logic signed [VW-1:0] gy_out,
	output logic [F:0] phi,
	output logic last_out
);
	import esl_pkg::*;
	localparam int PW = F + 1;
	localparam int QB = F + 2;
	localparam int CMW = (BETA_WIDTH > PW + 1) ? BETA_WIDTH : PW + 1;
	localparam int PEW = PW + VW + 2;
	localparam int XW = PEW + 1;
	localparam logic [QB-1:0] ONE_Q = QB'(1) << F;
	localparam logic [PW-1:0] ONE_P = PW'(1) << F;
	localparam logic [CMW-1:0] ONE_C = CMW'(1) << F;

	function automatic logic signed [VW-1:0] sat_v(input logic signed [XW-1:0] x);
		logic signed [XW-1:0] hi, lo;
		hi = XW'({1'b0, {(VW-1){1'b1}}});
		lo = ~hi;
		if (x > hi) return hi[VW-1:0];
		if (x < lo) return lo[VW-1:0];
		return x[VW-1:0];
	endfunction

	// unpack side data
	logic signed [VW:0] dq [3];
	logic signed [VW-1:0] qc, gx, gy;
	logic last;
	logic [2:0] dz;
	assign dq[0] = side[VW:0];
	assign dq[1] = side[2*VW+1:VW+1];
	assign dq[2] = side[3*VW+2:2*VW+2];
	assign qc = side[4*VW+2:3*VW+3];
	assign gx = side[5*VW+2:4*VW+3];
	assign gy = side[6*VW+2:5*VW+3];
	assign last = side[6*VW+3];
	assign dz = side[6*VW+6:6*VW+4];

	// candidate clamp and minimum
	logic [PW-1:0] bclamp, cand [3], phi_c;
	assign bclamp = (CMW'(beta) >= ONE_C) ? ONE_P : PW'(beta);
	always_comb begin
		phi_c = ONE_P;
		for (int i = 0; i < 3; i++) begin
			if (dz[i]) cand[i] = bclamp;
			else if (ovf[i] || quo[i] > ONE_Q) cand[i] = ONE_P;
			else cand[i] = quo[i][PW-1:0];
			if (cand[i] < phi_c) phi_c = cand[i];
		end
	end

	logic [PW-1:0] phi_b1, phi_b2, phi_b3, phi_b4;
	logic signed [VW:0] dq_b1 [3];
	logic signed [VW-1:0] qc_b1, gx_b1, gy_b1, qc_b2;
	logic last_b1, last_b2, last_b3, last_b4;
	logic signed [PEW-1:0] pe_b2 [3];
	logic signed [PEW-1:0] pgx_b2, pgy_b2;
	logic signed [VW-1:0] e_b3 [3], gx_b3, gy_b3;
	logic signed [VW-1:0] e_b4 [3], v_b4 [3], gx_b4, gy_b4;

	// stage B1
	always_ff @(posedge clk) begin
		if (en[0]) begin
			phi_b1 <= phi_c;
			dq_b1 <= dq;
			qc_b1 <= qc;
			gx_b1 <= gx;
			gy_b1 <= gy;
			last_b1 <= last;
		end
	end

	// stage B2: products with phi
	logic signed [PW:0] phi_sx;
	assign phi_sx = {1'b0, phi_b1};
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) pe_b2[i] <= phi_sx * dq_b1[i];
			pgx_b2 <= phi_sx * gx_b1;
			pgy_b2 <= phi_sx * gy_b1;
			qc_b2 <= qc_b1;
			phi_b2 <= phi_b1;
			last_b2 <= last_b1;
		end
	end

	// stage B3: floor rescale, add centre, saturate
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++)
				e_b3[i] <= sat_v(XW'(qc_b2) + XW'(pe_b2[i] >>> F));
			gx_b3 <= sat_v(XW'(pgx_b2 >>> F));
			gy_b3 <= sat_v(XW'(pgy_b2 >>> F));
			phi_b3 <= phi_b2;
			last_b3 <= last_b2;
		end
	end

	// stage B4: vertices, output register
	always_ff @(posedge clk) begin
		if (en[3]) begin
			e_b4 <= e_b3;
			v_b4[0] <= sat_v(XW'(e_b3[1]) + XW'(e_b3[2]) - XW'(e_b3[0]));
			v_b4[1] <= sat_v(XW'(e_b3[2]) + XW'(e_b3[0]) - XW'(e_b3[1]));
			v_b4[2] <= sat_v(XW'(e_b3[0]) + XW'(e_b3[1]) - XW'(e_b3[2]));
			gx_b4 <= gx_b3;
			gy_b4 <= gy_b3;
			phi_b4 <= phi_b3;
			last_b4 <= last_b3;
		end
	end

	assign edge_lim = e_b4;
	assign vertex = v_b4;
	assign gx_out = gx_b4;
	assign gy_out = gy_b4;
	assign phi = phi_b4;
	assign last_out = last_b4;
endmodule

// File: rtl/core/edge_slope_limiter.sv
// Edge slope limiter for one triangle per item: stream in, stream out.
// Slave channel s_axis_*: one triangle per item, tlast marks the final one.
// Master channel m_axis_*: one limited result per item, tlast copied through.
// cfg_wr_en/cfg_wr_data write the limiter strength beta (unsigned Q2.16);
// write it only while the pipeline is empty.
// The pipeline has two front stages, FRAC_BITS + 3 divider stages (an entry
// stage that flags overflow, then one quotient bit per stage) and four back
// stages. One item per cycle is taken in steady state while m_axis_tready is high.
// Each stage has its own valid bit and loads when empty or when the stage
// after it moves, so bubbles close up and the input keeps being accepted
// while a result waits at the output, until the pipeline is full.
// When m_axis_tready is low the output register holds its item.
// Reset empties all stages and sets beta to 1.0; no clearing pass is needed.
// Depends on esl_pkg, esl_front, esl_div, esl_back.
module edge_slope_limiter #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [esl_pkg::BETA_WIDTH-1:0] cfg_wr_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// centre, nbr0, nbr1, nbr2, nbr_present_mask, edge0, edge1, edge2, x_grad, y_grad
	input  logic [((9*VALUE_WIDTH+3+7)/8)*8-1:0] s_axis_tdata,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// edge0..2_limited, vertex0..2, x_grad_out, y_grad_out, limiter_phi
	output logic [((8*VALUE_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] m_axis_tdata,
	output logic m_axis_tlast
);
	import esl_pkg::*;
	localparam int VW = VALUE_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int PW = F + 1;
	localparam int QB = F + 2;
	localparam int NW = VW + BETA_WIDTH;
	localparam int NS = QB + 7;
	localparam int SW = 6*VW + 7;
	localparam int OW = ((8*VW+PW+7)/8)*8;

	logic [BETA_WIDTH-1:0] beta_q;
	logic [NS-1:0] en;
	logic vld_s [NS];

	// beta register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) beta_q <= BETA_RESET;
		else if (cfg_wr_en) beta_q <= cfg_wr_data;
	end

	// per-stage load enables: load when empty or when downstream moves
	always_comb begin
		en[NS-1] = !vld_s[NS-1] || m_axis_tready;
		for (int k = NS-2; k >= 0; k--) en[k] = !vld_s[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) vld_s[k] <= 1'b0;
		end else begin
			if (en[0]) vld_s[0] <= s_axis_tvalid;
			for (int k = 1; k < NS; k++)
				if (en[k]) vld_s[k] <= vld_s[k-1];
		end
	end

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = vld_s[NS-1];

	// input unpacking
	logic signed [VW-1:0] nbr [3], edge_v [3];
	assign nbr[0] = s_axis_tdata[2*VW-1:VW];
	assign nbr[1] = s_axis_tdata[3*VW-1:2*VW];
	assign nbr[2] = s_axis_tdata[4*VW-1:3*VW];
	assign edge_v[0] = s_axis_tdata[5*VW+2:4*VW+3];
	assign edge_v[1] = s_axis_tdata[6*VW+2:5*VW+3];
	assign edge_v[2] = s_axis_tdata[7*VW+2:6*VW+3];

	logic [NW-1:0] num [3];
	logic [VW-1:0] den [3];
	logic [SW-1:0] side_f;

	esl_front #(.VW(VW), .SW(SW)) u_front (
		.clk(clk), .en(en[1:0]), .beta(beta_q),
		.centre(s_axis_tdata[VW-1:0]), .nbr(nbr), .mask(s_axis_tdata[4*VW+2:4*VW]),
		.edge_v(edge_v), .gx(s_axis_tdata[8*VW+2:7*VW+3]),
		.gy(s_axis_tdata[9*VW+2:8*VW+3]), .last(s_axis_tlast),
		.num(num), .den(den), .side(side_f)
	);

	// three dividers, one per edge
	logic [QB-1:0] quo [3];
	logic [2:0] ovf;
	for (genvar i = 0; i < 3; i++) begin : g_div
		esl_div #(.NW(NW), .DW(VW), .QB(QB)) u_div (
			.clk(clk), .en(en[QB+2:2]),
			.num(num[i]), .den(den[i]), .quo(quo[i]), .ovf(ovf[i])
		);
	end

	// side data travels alongside the dividers
	logic [SW-1:0] side_s [QB+1];
	always_ff @(posedge clk) begin
		if (en[2]) side_s[0] <= side_f;
		for (int k = 1; k <= QB; k++)
			if (en[2+k]) side_s[k] <= side_s[k-1];
	end

	logic signed [VW-1:0] edge_lim [3], vertex [3], gx_o, gy_o;
	logic [PW-1:0] phi;

	esl_back #(.VW(VW), .F(F), .SW(SW)) u_back (
		.clk(clk), .en(en[NS-1:NS-4]), .beta(beta_q),
		.quo(quo), .ovf(ovf), .side(side_s[QB]),
		.edge_lim(edge_lim), .vertex(vertex), .gx_out(gx_o), .gy_out(gy_o),
		.phi(phi), .last_out(m_axis_tlast)
	);

	assign m_axis_tdata = OW'({phi, gy_o, gx_o, vertex[2], vertex[1], vertex[0],
		edge_lim[2], edge_lim[1], edge_lim[0]});
endmodule

// File: rtl/core/esl_checker.sv
// Port-level checks on the edge slope limiter, bound to the top level.
// Depends on assert_macros.svh and edge_slope_limiter.
`include "assert_macros.svh"
module esl_checker #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((8*VALUE_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] m_axis_tdata,
	input logic m_axis_tlast
);
	localparam int LO = 8*VALUE_WIDTH;
	localparam int HI = LO + FRAC_BITS;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	// stalled item stays valid
	`ESL_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output item dropped while stalled")
	// stalled item keeps its payload
	`ESL_ASSERT(a_hold_data, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")
	// phi never above one
	`ESL_ASSERT(a_phi_range, m_axis_tvalid |-> m_axis_tdata[HI:LO] <= ONE, "phi above 1.0")
	// empty output stage means the pipeline can take an item
	`ESL_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")
	// nothing leaves during reset
	`ESL_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_axis_tvalid, "output valid in reset")
endmodule

bind edge_slope_limiter esl_checker #(
	.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)
) u_esl_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
